/* sv/gradient_orientation_score_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the gradient orientation score core
// Immediate-consequence and next-cycle checks, sampled on the rising edge.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_ORIENTATION_SCORE_CORE_ASSERT_SVH
`define GRADIENT_ORIENTATION_SCORE_CORE_ASSERT_SVH

// same-cycle implication
`define GOS_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("gos assertion failed");

// next-cycle implication
`define GOS_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("gos assertion failed");

`endif

/* sv/gos_pkg.sv */
// ----------------------------------------------------------------------------
// gos_pkg
// Types and constants shared by the gradient orientation score core.
// ----------------------------------------------------------------------------
package gos_pkg;

  localparam int FOLD_W     = 19;   // folded angle, up to 20-bit angles
  localparam int COS_W      = 16;   // |cos| in Q1.15, 0..32768
  localparam int QUO_W      = 16;
  localparam int DIV_STEPS  = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int NPOLY      = 5;
  localparam int CFG_IDX_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MAG_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTSIDE_SCORE = 8'd1;

  localparam logic [30:0] COEF_C1 = 31'd1324675879;
  localparam logic [30:0] COEF_C2 = 31'd272375563;
  localparam logic [30:0] COEF_C3 = 31'd22402089;
  localparam logic [30:0] COEF_C4 = 31'd987048;
  localparam logic [30:0] COEF_C5 = 31'd27060;

  localparam logic [30:0] POLY_COEF [NPOLY-1] = '{COEF_C4, COEF_C3, COEF_C2, COEF_C1};

  localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;
  localparam logic signed [33:0] RND_HALF = 34'sd16384;
  localparam logic [COS_W-1:0]   COS_ONE  = 16'd32768;

  typedef struct packed {
    logic [15:0] gradient_angle;
    logic [15:0] gradient_magnitude;
    logic [15:0] normal_angle;
    logic        outside_image;
    logic        last_point;
  } gos_in_t;

  typedef struct packed {
    logic signed [16:0] mean_score;
    logic [12:0]        point_count;
  } gos_out_t;

  typedef enum logic [1:0] {
    PT_NONE,
    PT_ALIGN,
    PT_OUTSIDE
  } gos_kind_t;

  typedef struct packed {
    gos_kind_t kind;
    logic      last;
  } gos_tag_t;

  typedef struct packed {
    gos_tag_t          tag;
    logic [FOLD_W-1:0] fold;
  } gos_op_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_HOLD
  } gos_div_state_t;

endpackage

/* sv/gos_front.sv */
// ----------------------------------------------------------------------------
// gos_front
// Classifies an incoming point and folds its angle difference into the
// first quadrant.
// ----------------------------------------------------------------------------
module gos_front import gos_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  gos_in_t     point,
  input  logic [15:0] magnitude_threshold,
  output gos_op_t     op
);

  localparam int XW = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;
  localparam logic [ANGLE_BITS-2:0] QUARTER = (ANGLE_BITS-1)'(1) << (ANGLE_BITS - 2);

  logic [XW-1:0]         ga;
  logic [XW-1:0]         na;
  logic [XW-1:0]         diff;
  logic [ANGLE_BITS-1:0] d;
  logic [ANGLE_BITS-2:0] r;
  logic [ANGLE_BITS-2:0] a;

  always_comb begin
    ga   = XW'(point.gradient_angle);
    na   = XW'(point.normal_angle);
    diff = ga - na;
    d    = diff[ANGLE_BITS-1:0];
    r    = {1'b0, d[ANGLE_BITS-3:0]};
    a    = d[ANGLE_BITS-2] ? (QUARTER - r) : r;
  end

  always_comb begin
    op.fold     = FOLD_W'(a);
    op.tag.last = point.last_point;
    priority if (point.outside_image) begin
      op.tag.kind = PT_OUTSIDE;
    end else if (point.gradient_magnitude > magnitude_threshold) begin
      op.tag.kind = PT_ALIGN;
    end else begin
      op.tag.kind = PT_NONE;
    end
  end

endmodule

/* sv/gos_fifo.sv */
// ----------------------------------------------------------------------------
// gos_fifo
// Short queue of classified points between the front and the back.
// ----------------------------------------------------------------------------
`include "gradient_orientation_score_core_assert.svh"

module gos_fifo import gos_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  gos_op_t din,
  input  logic    pop,
  output gos_op_t dout,
  output logic    full,
  output logic    empty
);

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  gos_op_t            q_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;

  assign full  = (fill == FILL_W'(FIFO_DEPTH));
  assign empty = (fill == '0);
  assign dout  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  `GOS_ASSERT_IMP(a_fifo_fill_bound, clk, rst, 1'b1, fill <= FILL_W'(FIFO_DEPTH))
  `GOS_ASSERT_IMP(a_fifo_pop_nonempty, clk, rst, pop, fill != '0)
  `GOS_ASSERT_IMP(a_fifo_push_not_full, clk, rst, push, !full)

endmodule

/* sv/gos_cos_pipe.sv */
// ----------------------------------------------------------------------------
// gos_cos_pipe
// Pipelined quarter-wave |cos| evaluation, at most one multiply per stage.
// ----------------------------------------------------------------------------
module gos_cos_pipe import gos_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  gos_op_t          in_op,
  output logic             out_valid,
  output gos_tag_t         out_tag,
  output logic [COS_W-1:0] out_cos
);

  localparam int STAGES  = NPOLY + 2;
  localparam int T_SHIFT = 32 - ANGLE_BITS;

  logic [STAGES-1:0] vld;
  gos_tag_t          tag_q  [STAGES];
  logic [61:0]       sq_q;
  logic [30:0]       u_q    [1:NPOLY-1];
  logic [61:0]       prod_q [1:NPOLY];
  logic [COS_W-1:0]  cos_q;

  logic [30:0]       t;
  logic [61:0]       sq_d;
  logic [30:0]       u_d;
  logic [30:0]       p_k    [2:NPOLY];
  logic [61:0]       prod_d [1:NPOLY];
  logic signed [33:0] v;
  logic signed [33:0] rnd;
  logic [18:0]       res;
  logic [COS_W-1:0]  cos_d;

  always_comb begin
    t         = 31'(in_op.fold) << T_SHIFT;
    sq_d      = t * t;
    u_d       = sq_q[60:30];
    prod_d[1] = u_d * COEF_C5;
    for (int k = 2; k <= NPOLY; k++) begin
      p_k[k]    = POLY_COEF[k-2] - prod_q[k-1][60:30];
      prod_d[k] = u_q[k-1] * p_k[k];
    end
  end

  always_comb begin
    v   = ONE_Q30 - $signed({2'b00, prod_q[NPOLY][61:30]});
    rnd = v + RND_HALF;
    res = rnd[33:15];
    if (v <= 0) begin
      cos_d = '0;
    end else if (res > 19'(COS_ONE)) begin
      cos_d = COS_ONE;
    end else begin
      cos_d = res[COS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_q[0]  <= in_op.tag;
      sq_q      <= sq_d;
      u_q[1]    <= u_d;
      prod_q[1] <= prod_d[1];
      for (int k = 1; k < STAGES; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
      for (int k = 2; k < NPOLY; k++) begin
        u_q[k] <= u_q[k-1];
      end
      for (int k = 2; k <= NPOLY; k++) begin
        prod_q[k] <= prod_d[k];
      end
      cos_q <= cos_d;
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_tag   = tag_q[STAGES-1];
  assign out_cos   = cos_q;

endmodule

/* sv/gos_accum.sv */
// ----------------------------------------------------------------------------
// gos_accum
// Score accumulation, point counting and the rounded mean divider.
// ----------------------------------------------------------------------------
`include "gradient_orientation_score_core_assert.svh"

module gos_accum import gos_pkg::*; #(
  parameter int MAX_POINTS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [15:0] outside_point_score,
  input  logic               in_valid,
  input  gos_tag_t           in_tag,
  input  logic [COS_W-1:0]   in_cos,
  output logic               in_ready,
  output logic               score_valid,
  input  logic               score_ready,
  output gos_out_t           score
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = CNT_W + 16;
  localparam int RW     = CNT_W + 17;
  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam int CXW    = (CNT_W > 13) ? CNT_W : 13;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_next;

  gos_div_state_t          div_state;
  gos_div_state_t          div_state_next;
  logic [RW-1:0]           rem;
  logic [RW-1:0]           dsh;
  logic [QUO_W-1:0]        quo;
  logic [STEP_W-1:0]       step;
  logic                    neg;
  logic [CNT_W-1:0]        cnt_hold;

  logic                    take;
  logic                    load;
  logic                    room;
  logic signed [SUM_W-1:0] addend;
  logic signed [SUM_W-1:0] sum_acc;
  logic [CNT_W-1:0]        cnt_acc;
  logic [SUM_W-1:0]        mag;
  logic [RW-1:0]           rem_init;
  logic [RW-1:0]           dsh_init;
  logic                    ge;
  logic                    div_shift;
  logic                    res_load;
  logic [QUO_W:0]          quo_ext;
  logic [CXW-1:0]          cnt_ext;

  assign in_ready = !in_tag.last || (div_state == DIV_IDLE);
  assign take     = in_valid && in_ready;
  assign load     = take && in_tag.last;
  assign room     = cnt < CNT_W'(MAX_POINTS);

  always_comb begin
    unique case (in_tag.kind)
      PT_OUTSIDE: addend = {{(SUM_W-16){outside_point_score[15]}}, outside_point_score};
      PT_ALIGN:   addend = $signed({{(SUM_W-COS_W){1'b0}}, in_cos});
      default:    addend = '0;
    endcase
  end

  always_comb begin
    sum_acc  = room ? (sum + addend) : sum;
    cnt_acc  = room ? (cnt + 1'b1) : cnt;
    sum_next = sum;
    cnt_next = cnt;
    if (take) begin
      sum_next = in_tag.last ? '0 : sum_acc;
      cnt_next = in_tag.last ? '0 : cnt_acc;
    end
    mag      = sum_acc[SUM_W-1] ? SUM_W'(-sum_acc) : SUM_W'(sum_acc);
    rem_init = (RW'(mag) << 1) + RW'(cnt_acc);
    dsh_init = RW'(cnt_acc) << DIV_STEPS;
    ge       = (rem >= dsh);
  end

  always_comb begin
    div_state_next = div_state;
    unique case (div_state)
      DIV_IDLE: if (load) div_state_next = DIV_RUN;
      DIV_RUN:  if (step == '0) div_state_next = DIV_HOLD;
      DIV_HOLD: if (!score_valid || score_ready) div_state_next = DIV_IDLE;
      default:  div_state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    div_shift = 1'b0;
    res_load  = 1'b0;
    unique case (div_state)
      DIV_RUN:  div_shift = 1'b1;
      DIV_HOLD: res_load  = !score_valid || score_ready;
      default: begin
        div_shift = 1'b0;
        res_load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum         <= '0;
      cnt         <= '0;
      div_state   <= DIV_IDLE;
      score_valid <= 1'b0;
    end else begin
      sum       <= sum_next;
      cnt       <= cnt_next;
      div_state <= div_state_next;
      if (res_load) begin
        score_valid <= 1'b1;
      end else if (score_ready) begin
        score_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem      <= rem_init;
      dsh      <= dsh_init;
      quo      <= '0;
      step     <= STEP_W'(DIV_STEPS - 1);
      neg      <= sum_acc[SUM_W-1];
      cnt_hold <= cnt_acc;
    end else if (div_shift) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quo  <= {quo[QUO_W-2:0], ge};
      dsh  <= dsh >> 1;
      step <= step - 1'b1;
    end
  end

  assign quo_ext = {1'b0, quo};
  assign cnt_ext = CXW'(cnt_hold);

  always_ff @(posedge clk) begin
    if (res_load) begin
      score.mean_score  <= neg ? $signed(-quo_ext) : $signed(quo_ext);
      score.point_count <= cnt_ext[12:0];
    end
  end

  `GOS_ASSERT_IMP(a_last_only_when_idle, clk, rst, load, div_state == DIV_IDLE)
  `GOS_ASSERT_NXT(a_hold_while_blocked, clk, rst,
                  div_state == DIV_HOLD && score_valid && !score_ready,
                  div_state == DIV_HOLD)
  `GOS_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, cnt <= CNT_W'(MAX_POINTS))

endmodule

/* sv/gradient_orientation_score_core.sv */
// ----------------------------------------------------------------------------
// gradient_orientation_score_core
// Mean gradient/normal alignment score over a set of sampled edge points.
// ----------------------------------------------------------------------------
//  channel  | signals                                | payload
//  ---------+----------------------------------------+----------------------
//  point    | point_valid / point_ready              | gos_in_t
//  score    | score_valid / score_ready              | gos_out_t
//  cfg      | cfg_valid / cfg_ready (always ready)   | cfg_index, cfg_data
//
//  One point per cycle is sustained unless the accumulator stalls; a point takes
//  a queue slot, then the 7-stage |cos| pipeline (at most one multiply per stage)
//  before it is summed. A last point starts the divider, and a further last point
//  waits until the divider is free; the score is registered once the output is free.
//  Reset clears sums, counts, queue and valid bits; no clearing pass.
//  A stalled score output backs up the divider, then the pipeline, then point.
// ----------------------------------------------------------------------------
module gradient_orientation_score_core import gos_pkg::*; #(
  parameter int MAX_POINTS = 4096,
  parameter int ANGLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 point_valid,
  output logic                 point_ready,
  input  gos_in_t              point,
  output logic                 score_valid,
  input  logic                 score_ready,
  output gos_out_t             score,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [15:0]        magnitude_threshold;
  logic signed [15:0] outside_point_score;

  gos_op_t            front_op;
  gos_op_t            head_op;
  logic               fifo_full;
  logic               fifo_empty;
  logic               push;
  logic               pop;
  logic               pipe_en;
  logic               tail_valid;
  gos_tag_t           tail_tag;
  logic [COS_W-1:0]   tail_cos;
  logic               acc_ready;

  assign cfg_ready   = 1'b1;
  assign point_ready = !fifo_full;
  assign push        = point_valid && !fifo_full;
  assign pipe_en     = !tail_valid || acc_ready;
  assign pop         = !fifo_empty && pipe_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude_threshold <= '0;
      outside_point_score <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MAG_THRESHOLD) begin
        magnitude_threshold <= cfg_data;
      end
      if (cfg_index == CFG_OUTSIDE_SCORE) begin
        outside_point_score <= $signed(cfg_data);
      end
    end
  end

  gos_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .point              (point),
    .magnitude_threshold(magnitude_threshold),
    .op                 (front_op)
  );

  gos_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (front_op),
    .pop  (pop),
    .dout (head_op),
    .full (fifo_full),
    .empty(fifo_empty)
  );

  gos_cos_pipe #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_cos_pipe (
    .clk      (clk),
    .rst      (rst),
    .en       (pipe_en),
    .in_valid (pop),
    .in_op    (head_op),
    .out_valid(tail_valid),
    .out_tag  (tail_tag),
    .out_cos  (tail_cos)
  );

  gos_accum #(
    .MAX_POINTS(MAX_POINTS)
  ) u_accum (
    .clk                (clk),
    .rst                (rst),
    .outside_point_score(outside_point_score),
    .in_valid           (tail_valid),
    .in_tag             (tail_tag),
    .in_cos             (tail_cos),
    .in_ready           (acc_ready),
    .score_valid        (score_valid),
    .score_ready        (score_ready),
    .score              (score)
  );

endmodule
